@@ rtl/core/scd_pkg.sv @@
// Shared package for the settable clock with segment display.
// Holds register defaults, key and edit-state codes, the time bundle type
// and the seven-segment digit encoding functions. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package scd_pkg;

    localparam int TpsWidth   = 10;
    localparam int BlinkWidth = 8;

    localparam logic [TpsWidth-1:0]   TpsReset   = 10'd20;
    localparam logic [BlinkWidth-1:0] BlinkReset = 8'd6;

    // configuration register select (paddr bit 2)
    localparam logic REG_TICKS_PER_SECOND  = 1'b0;
    localparam logic REG_BLINK_HALF_PERIOD = 1'b1;

    localparam logic KIND_TICK = 1'b0;

    localparam logic [3:0] KEY_STEP = 4'd1;
    localparam logic [3:0] KEY_UP   = 4'd2;
    localparam logic [3:0] KEY_DOWN = 4'd4;

    localparam logic [7:0] SEG_DASH = 8'h40;
    localparam logic [7:0] SEG_MARK = 8'h80;

    typedef enum logic [1:0] {
        EDIT_RUN  = 2'd0,
        EDIT_MIN  = 2'd1,
        EDIT_HOUR = 2'd2
    } edit_state_t;

    typedef struct packed {
        logic [4:0]  hours;
        logic [5:0]  minutes;
        logic [5:0]  seconds;
        edit_state_t edit;
        logic        blink;
    } scd_time_t;

    function automatic logic [7:0] seg_digit(input logic [3:0] d);
        logic [7:0] code;
        case (d)
            4'd0:    code = 8'h3F;
            4'd1:    code = 8'h06;
            4'd2:    code = 8'h5B;
            4'd3:    code = 8'h4F;
            4'd4:    code = 8'h66;
            4'd5:    code = 8'h6D;
            4'd6:    code = 8'h7D;
            4'd7:    code = 8'h07;
            4'd8:    code = 8'h7F;
            4'd9:    code = 8'h6F;
            default: code = 8'h00;
        endcase
        return code;
    endfunction

    // tens code in the low byte, ones code in the high byte
    function automatic logic [15:0] digit_pair(input logic [5:0] v);
        logic [3:0] tens;
        logic [5:0] base;
        logic [5:0] ones;
        if (v >= 6'd60) begin
            tens = 4'd6;
        end else if (v >= 6'd50) begin
            tens = 4'd5;
        end else if (v >= 6'd40) begin
            tens = 4'd4;
        end else if (v >= 6'd30) begin
            tens = 4'd3;
        end else if (v >= 6'd20) begin
            tens = 4'd2;
        end else if (v >= 6'd10) begin
            tens = 4'd1;
        end else begin
            tens = 4'd0;
        end
        base = {tens[2:0], 3'b000} + {1'b0, tens[2:0], 1'b0};
        ones = v - base;
        return {seg_digit(ones[3:0]), seg_digit(tens)};
    endfunction

endpackage

`default_nettype wire

@@ rtl/core/settable_clock_with_segment_display.sv @@
// Settable clock top level: tick and key beats in, time plus segment image out.
// Uses scd_pkg and scd_seg_enc.
//
// Input channel (s_): each beat is a timer tick (s_mode 0) or a key press
// (s_mode 1, s_key_code 1 step mode, 2 up, 4 down, anything else no effect).
// Result channel (m_): one beat per input beat with hours, minutes, seconds,
// set_state, blink_phase and the eight-byte segment image.
// Throughput: one beat per cycle while no result is held back by m_ready low;
// the clock state and the result register update in the same edge that
// accepts the input beat.
// A stalled result holds in the result register; a new input beat is taken
// in the same cycle the held result leaves, so no bubble comes between them.
// Reset (aresetn low, synchronous) clears the time, dividers, blink phase and
// edit state, drops any pending result and loads the divider registers
// with 20 ticks per second and a blink half period of 6.
// APB registers: 0x0 ticks_per_second [9:0], 0x4 blink_half_period [7:0];
// write them only while no beat is in flight.
`timescale 1ns / 1ps
`default_nettype none

module settable_clock_with_segment_display
    import scd_pkg::*;
(
    input  wire                aclk,
    input  wire                aresetn,

    input  wire                psel,
    input  wire                penable,
    input  wire                pwrite,
    input  wire  [2:0]         paddr,
    input  wire  [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready,

    input  wire                s_valid,
    output logic               s_ready,
    input  wire                s_mode,
    input  wire  [3:0]         s_key_code,

    output logic               m_valid,
    input  wire                m_ready,
    output logic [4:0]         m_hours,
    output logic [5:0]         m_minutes,
    output logic [5:0]         m_seconds,
    output logic [1:0]         m_set_state,
    output logic               m_blink_phase,
    output logic [63:0]        m_segments
);

    logic [TpsWidth-1:0]   tps_reg;
    logic [BlinkWidth-1:0] blink_half_reg;

    logic [TpsWidth-1:0]   tick_count_reg,  tick_count_next;
    logic [BlinkWidth-1:0] blink_count_reg, blink_count_next;
    logic                  blink_bit_reg,   blink_bit_next;
    logic [5:0]            second_reg,      second_next;
    logic [5:0]            minute_reg,      minute_next;
    logic [4:0]            hour_reg,        hour_next;
    edit_state_t           edit_reg,        edit_next;

    logic                  m_valid_reg,     m_valid_next;
    scd_time_t             res_time_reg;
    logic [63:0]           res_seg_reg;

    logic                  s_beat;
    logic                  cfg_write;
    logic                  sec_fire;
    scd_time_t             time_next;
    logic [63:0]           seg_next;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;
    assign prdata    = (paddr[2] == REG_BLINK_HALF_PERIOD)
                       ? {{(32-BlinkWidth){1'b0}}, blink_half_reg}
                       : {{(32-TpsWidth){1'b0}}, tps_reg};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tps_reg        <= TpsReset;
            blink_half_reg <= BlinkReset;
        end else if (cfg_write) begin
            if (paddr[2] == REG_TICKS_PER_SECOND) begin
                tps_reg <= pwdata[TpsWidth-1:0];
            end else begin
                blink_half_reg <= pwdata[BlinkWidth-1:0];
            end
        end
    end

    assign s_ready = !m_valid_reg || m_ready;
    assign s_beat  = s_valid && s_ready;

    // next clock state
    always_comb begin
        tick_count_next  = tick_count_reg;
        blink_count_next = blink_count_reg;
        blink_bit_next   = blink_bit_reg;
        second_next      = second_reg;
        minute_next      = minute_reg;
        hour_next        = hour_reg;
        edit_next        = edit_reg;
        sec_fire         = 1'b0;
        if (s_beat) begin
            if (s_mode == KIND_TICK) begin
                if ({1'b0, blink_count_reg} + 9'd1 >= {1'b0, blink_half_reg}) begin
                    blink_count_next = '0;
                    blink_bit_next   = !blink_bit_reg;
                end else begin
                    blink_count_next = blink_count_reg + 8'd1;
                end
                if ({1'b0, tick_count_reg} + 11'd1 >= {1'b0, tps_reg}) begin
                    tick_count_next = '0;
                    sec_fire        = (edit_reg == EDIT_RUN);
                end else begin
                    tick_count_next = tick_count_reg + 10'd1;
                end
                if (sec_fire) begin
                    if (second_reg >= 6'd59) begin
                        second_next = '0;
                        if (minute_reg >= 6'd59) begin
                            minute_next = '0;
                            hour_next   = (hour_reg >= 5'd23) ? 5'd0 : hour_reg + 5'd1;
                        end else begin
                            minute_next = minute_reg + 6'd1;
                        end
                    end else begin
                        second_next = second_reg + 6'd1;
                    end
                end
            end else begin
                case (s_key_code)
                    KEY_STEP: begin
                        unique case (edit_reg)
                            EDIT_RUN:  edit_next = EDIT_MIN;
                            EDIT_MIN:  edit_next = EDIT_HOUR;
                            default: begin
                                edit_next   = EDIT_RUN;
                                second_next = '0;
                            end
                        endcase
                    end
                    KEY_UP: begin
                        if (edit_reg == EDIT_MIN) begin
                            minute_next = (minute_reg >= 6'd59) ? 6'd0 : minute_reg + 6'd1;
                        end else if (edit_reg == EDIT_HOUR) begin
                            hour_next = (hour_reg >= 5'd23) ? 5'd0 : hour_reg + 5'd1;
                        end
                    end
                    KEY_DOWN: begin
                        if (edit_reg == EDIT_MIN) begin
                            minute_next = (minute_reg == 6'd0) ? 6'd59 : minute_reg - 6'd1;
                        end else if (edit_reg == EDIT_HOUR) begin
                            hour_next = (hour_reg == 5'd0) ? 5'd23 : hour_reg - 5'd1;
                        end
                    end
                    default: ;
                endcase
            end
        end
    end

    always_comb begin
        time_next.hours   = hour_next;
        time_next.minutes = minute_next;
        time_next.seconds = second_next;
        time_next.edit    = edit_next;
        time_next.blink   = blink_bit_next;
        m_valid_next      = s_beat ? 1'b1 : (m_ready ? 1'b0 : m_valid_reg);
    end

    scd_seg_enc u_seg_enc (
        .time_in  (time_next),
        .segments (seg_next)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tick_count_reg  <= '0;
            blink_count_reg <= '0;
            blink_bit_reg   <= 1'b0;
            second_reg      <= '0;
            minute_reg      <= '0;
            hour_reg        <= '0;
            edit_reg        <= EDIT_RUN;
            m_valid_reg     <= 1'b0;
        end else begin
            tick_count_reg  <= tick_count_next;
            blink_count_reg <= blink_count_next;
            blink_bit_reg   <= blink_bit_next;
            second_reg      <= second_next;
            minute_reg      <= minute_next;
            hour_reg        <= hour_next;
            edit_reg        <= edit_next;
            m_valid_reg     <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_beat) begin
            res_time_reg <= time_next;
            res_seg_reg  <= seg_next;
        end
    end

    assign m_valid       = m_valid_reg;
    assign m_hours       = res_time_reg.hours;
    assign m_minutes     = res_time_reg.minutes;
    assign m_seconds     = res_time_reg.seconds;
    assign m_set_state   = res_time_reg.edit;
    assign m_blink_phase = res_time_reg.blink;
    assign m_segments    = res_seg_reg;

    a_time_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (hour_reg <= 5'd23) && (minute_reg <= 6'd59) && (second_reg <= 6'd59))
        else $error("clock value out of range");

    a_tick_keeps_edit: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_beat && (s_mode == KIND_TICK)) |=> $stable(edit_reg))
        else $error("tick beat changed edit state");

    a_return_clears_sec: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_beat && (s_mode != KIND_TICK) && (s_key_code == KEY_STEP)
         && (edit_reg == EDIT_HOUR)) |=> (second_reg == 6'd0) && (edit_reg == EDIT_RUN))
        else $error("return to run did not clear seconds");

    a_hour_blank: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_blink_phase && (m_set_state == EDIT_HOUR)) |-> (m_segments[15:0] == 16'h0))
        else $error("hour digits not blanked");

    a_key_keeps_div: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_beat && (s_mode != KIND_TICK)) |=> $stable(tick_count_reg) && $stable(blink_bit_reg))
        else $error("key beat advanced a divider");

endmodule

`default_nettype wire

@@ rtl/core/scd_seg_enc.sv @@
// Seven-segment image encoder for the clock display.
// Turns a time bundle into eight segment bytes with edit blanking.
// Depends on scd_pkg.
`timescale 1ns / 1ps
`default_nettype none

module scd_seg_enc
    import scd_pkg::*;
(
    input  wire scd_time_t   time_in,
    output logic [63:0]      segments
);

    logic        blank_h;
    logic        blank_m;
    logic [15:0] hour_pair;
    logic [15:0] min_pair;
    logic [15:0] sec_pair;

    always_comb begin
        blank_h   = (time_in.edit == EDIT_HOUR) && time_in.blink;
        blank_m   = (time_in.edit == EDIT_MIN) && time_in.blink;
        hour_pair = blank_h ? 16'h0000 : digit_pair({1'b0, time_in.hours});
        min_pair  = blank_m ? 16'h0000 : digit_pair(time_in.minutes);
        sec_pair  = digit_pair(time_in.seconds);
        segments  = {sec_pair, SEG_MARK, min_pair, SEG_DASH, hour_pair};
    end

endmodule

`default_nettype wire
